/* rtl/core/scfd_pkg.sv */
// Package for the serial command frame decoder.
// Holds the byte codes, field widths, reset values and the result struct.
// No dependencies; every other file of the block depends on it.
package scfd_pkg;

   // Field widths.
   localparam int BYTE_W = 8;
   localparam int AMP_W  = 16;
   localparam int FREQ_W = 32;
   localparam int PHS_W  = 16;
   localparam int ACC_W  = 32;
   localparam int POS_W  = 6;

   // Default frame length limit; the position counter saturates here.
   localparam int MAX_FRAME_DEFAULT = 32;

   // Byte codes.
   localparam logic [BYTE_W-1:0] TERMINATOR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CMD_AMPLITUDE = 8'h0a;
   localparam logic [BYTE_W-1:0] CMD_LOAD      = 8'h0b;
   localparam logic [BYTE_W-1:0] SUB_ONE       = 8'h01;
   localparam logic [BYTE_W-1:0] SUB_TWO       = 8'h02;
   localparam logic [BYTE_W-1:0] DIGIT_BASE    = 8'd48;

   // Settings after reset.
   localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd801;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd1000;
   localparam logic [PHS_W-1:0]  PHS_RESET  = 16'd83;

   // One result item: the three settings after a frame.
   typedef struct packed {
      logic [AMP_W-1:0]  amplitude;
      logic [FREQ_W-1:0] frequency;
      logic [PHS_W-1:0]  phase;
   } result_type;

endpackage

/* rtl/core/scfd_if.sv */
// Channel interfaces of the serial command frame decoder.
// Depends on scfd_pkg for the field widths.
interface scfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [scfd_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scfd_pkg::AMP_W-1:0]    amplitude;
   logic [scfd_pkg::FREQ_W-1:0]   frequency;
   logic [scfd_pkg::PHS_W-1:0]    phase;

   modport source (output valid, output amplitude, output frequency, output phase,
                   input ready);
   modport sink   (input valid, input amplitude, input frequency, input phase,
                   output ready);
endinterface

/* rtl/core/scfd_in_reg.sv */
// Input register of the serial command frame decoder.
// Captures one received byte per transfer; depends on scfd_pkg.
module scfd_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [scfd_pkg::BYTE_W-1:0] req_byte,
   output logic                        req_ready,
   input  logic                        take,
   output logic                        hold_valid,
   output logic [scfd_pkg::BYTE_W-1:0] hold_byte
);
   import scfd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   // The register may refill in the same cycle that the decoder consumes it.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

/* rtl/core/scfd_decode.sv */
// Frame decoder of the serial command frame decoder: frame position,
// command bytes, decimal accumulator and the three settings. Depends on scfd_pkg.
module scfd_decode #(
   parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        hold_valid,
   input  logic [scfd_pkg::BYTE_W-1:0] hold_byte,
   input  logic                        out_free,
   output logic                        take,
   output logic                        emit,
   output scfd_pkg::result_type        result
);
   import scfd_pkg::*;

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME);

   logic [POS_W-1:0]  pos_ff, pos_in, pos_next;
   logic [BYTE_W-1:0] cmd_ff, cmd_in, cmd_new;
   logic [BYTE_W-1:0] sub_ff, sub_in, sub_new;
   logic [ACC_W-1:0]  acc_ff, acc_in, acc_next;
   logic [AMP_W-1:0]  amp_ff, amp_in, amp_new;
   logic [FREQ_W-1:0] freq_ff, freq_in, freq_new;
   logic [PHS_W-1:0]  phs_ff, phs_in, phs_new;
   logic [BYTE_W-1:0] digit;
   logic              is_term;

   // A terminator needs room in the result register; other bytes always go.
   assign is_term = (hold_byte == TERMINATOR);
   assign take    = hold_valid && (!is_term || out_free);
   assign emit    = take && is_term;

   // Position advances and saturates; the first two bytes are latched.
   always_comb begin
      pos_next = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : POS_MAX;
      cmd_new  = (pos_next == POS_W'(1)) ? hold_byte : cmd_ff;
      sub_new  = (pos_next == POS_W'(2)) ? hold_byte : sub_ff;
   end

   // Decimal accumulator: acc * 10 as two shifts, plus the digit value.
   always_comb begin
      digit    = (hold_byte >= DIGIT_BASE) ? hold_byte - DIGIT_BASE : '0;
      acc_next = {acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0}
                 + ACC_W'(digit);
   end

   // Command application on the terminator.
   always_comb begin
      amp_new  = amp_ff;
      freq_new = freq_ff;
      phs_new  = phs_ff;
      unique case (cmd_new)
         CMD_AMPLITUDE: begin
            if (sub_new == SUB_ONE) begin
               amp_new = amp_ff + AMP_W'(1);
            end else if (sub_new == SUB_TWO) begin
               amp_new = amp_ff - AMP_W'(1);
            end
         end
         CMD_LOAD: begin
            if (sub_new == SUB_ONE) begin
               freq_new = acc_ff;
            end else if (sub_new == SUB_TWO) begin
               phs_new = acc_ff[PHS_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Next state for one consumed byte.
   always_comb begin
      pos_in  = pos_ff;
      cmd_in  = cmd_ff;
      sub_in  = sub_ff;
      acc_in  = acc_ff;
      amp_in  = amp_ff;
      freq_in = freq_ff;
      phs_in  = phs_ff;
      if (take) begin
         cmd_in = cmd_new;
         sub_in = sub_new;
         if (is_term) begin
            pos_in  = '0;
            acc_in  = '0;
            amp_in  = amp_new;
            freq_in = freq_new;
            phs_in  = phs_new;
         end else begin
            pos_in = pos_next;
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cmd_ff  <= '0;
         sub_ff  <= '0;
         acc_ff  <= '0;
         amp_ff  <= AMP_RESET;
         freq_ff <= FREQ_RESET;
         phs_ff  <= PHS_RESET;
      end else begin
         pos_ff  <= pos_in;
         cmd_ff  <= cmd_in;
         sub_ff  <= sub_in;
         acc_ff  <= acc_in;
         amp_ff  <= amp_in;
         freq_ff <= freq_in;
         phs_ff  <= phs_in;
      end
   end

   // The result carries the settings as updated by this frame.
   assign result.amplitude = amp_new;
   assign result.frequency = freq_new;
   assign result.phase     = phs_new;

   // The frame position never passes the limit.
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("frame position beyond limit");

   // A terminator restarts the frame.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      take && is_term |=> pos_ff == '0 && acc_ff == '0)
      else $error("frame not restarted after terminator");

   // Any other byte leaves the frame position nonzero.
   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      take && !is_term |=> pos_ff != '0)
      else $error("frame position did not advance");

   // Settings change only on a terminator.
   a_settings_hold: assert property (@(posedge clock) disable iff (reset)
      !emit |=> $stable(amp_ff) && $stable(freq_ff) && $stable(phs_ff))
      else $error("settings changed without a terminator");

endmodule

/* rtl/core/scfd_out_reg.sv */
// Result register of the serial command frame decoder.
// Holds one result until the sink takes it; depends on scfd_pkg.
module scfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 emit,
   input  scfd_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output scfd_pkg::result_type rsp_data
);
   import scfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register is free when empty or when its transfer completes now.
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (emit) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/core/serial_command_frame_decoder.sv */
// Serial command frame decoder, top level. A byte waits in the input register
// and is decoded there; a terminator's result goes to the result register,
// waiting while it is full. Throughput: one byte per cycle through the single
// input register to result register pass, unless a full result register
// holds back a terminator and the bytes behind it. Synchronous active-high reset
// clears the frame state and loads amplitude 801, frequency 1000 and phase 83.
module serial_command_frame_decoder #(
   parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   scfd_req_if.sink   req_bus,
   scfd_rsp_if.source rsp_bus
);
   import scfd_pkg::*;

   logic              take, emit, out_free, hold_valid;
   logic [BYTE_W-1:0] hold_byte;
   result_type        result, rsp_data;

   // Input register.
   scfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_byte   (req_bus.rx_byte),
      .req_ready  (req_bus.ready),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   // Frame decoding and settings.
   scfd_decode #(
      .MAX_FRAME (MAX_FRAME)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte),
      .out_free   (out_free),
      .take       (take),
      .emit       (emit),
      .result     (result)
   );

   // Result register.
   scfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.amplitude = rsp_data.amplitude;
   assign rsp_bus.frequency = rsp_data.frequency;
   assign rsp_bus.phase     = rsp_data.phase;

endmodule
